@@ hw/rtl/csvfe_pkg.sv @@
package csvfe_pkg;

  // widths fixed by the record format
  localparam int CharW       = 8;
  localparam int FieldIndexW = 8;
  localparam int ModeW       = 3;

  // default width of the field counter
  localparam int DefIndexBits = 8;

  // special characters
  localparam logic [CharW-1:0] CharQuote = 8'h22;
  localparam logic [CharW-1:0] CharComma = 8'h2C;
  localparam logic [CharW-1:0] CharNul   = 8'h00;

  // scan mode codes
  localparam logic [ModeW-1:0] ModeStart      = 3'd0;
  localparam logic [ModeW-1:0] ModeSkipPlain  = 3'd1;
  localparam logic [ModeW-1:0] ModeSkipQuoted = 3'd2;
  localparam logic [ModeW-1:0] ModeSkipQpend  = 3'd3;
  localparam logic [ModeW-1:0] ModeTakePlain  = 3'd4;
  localparam logic [ModeW-1:0] ModeTakeQuoted = 3'd5;
  localparam logic [ModeW-1:0] ModeTakeQpend  = 3'd6;
  localparam logic [ModeW-1:0] ModeDone       = 3'd7;

  // one output word
  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             char_valid;
    logic             field_end;
  } csvfe_res_t;

endpackage

@@ hw/rtl/csvfe_step.sv @@
module csvfe_step import csvfe_pkg::*; #(
  parameter int INDEX_BITS = DefIndexBits
) (
  input  logic [ModeW-1:0]       mode_i,
  input  logic [INDEX_BITS-1:0]  count_i,
  input  logic [FieldIndexW-1:0] field_index_i,
  input  logic [CharW-1:0]       char_i,
  input  logic                   eor_i,
  output logic [ModeW-1:0]       mode_o,
  output logic [INDEX_BITS-1:0]  count_o,
  output logic                   emit_o,
  output csvfe_res_t             res_o
);

  logic [INDEX_BITS-1:0] idx_lo;
  logic [INDEX_BITS-1:0] tgt;
  logic                  at_tgt;
  logic [INDEX_BITS-1:0] count_inc;
  logic                  is_nul;
  logic                  is_comma;
  logic                  is_quote;

  // effective target field, zero acts as one
  assign idx_lo    = INDEX_BITS'(field_index_i);
  assign tgt       = (idx_lo == '0) ? INDEX_BITS'(1) : idx_lo;
  assign at_tgt    = (count_i >= tgt);
  // saturating count of the next field
  assign count_inc = at_tgt ? count_i : count_i + INDEX_BITS'(1);

  assign is_nul   = (char_i == CharNul);
  assign is_comma = (char_i == CharComma);
  assign is_quote = (char_i == CharQuote);

  // next scan state and result word
  always_comb begin
    mode_o  = mode_i;
    count_o = count_i;
    emit_o  = 1'b0;
    res_o   = '0;
    if (eor_i) begin
      if (mode_i != ModeDone) begin
        emit_o          = 1'b1;
        res_o.field_end = 1'b1;
      end
      mode_o  = ModeStart;
      count_o = INDEX_BITS'(1);
    end else begin
      unique case (mode_i)
        ModeStart: begin
          if (is_nul || (at_tgt && is_comma)) begin
            emit_o          = 1'b1;
            res_o.field_end = 1'b1;
            mode_o          = ModeDone;
          end else if (at_tgt) begin
            if (is_quote) begin
              mode_o = ModeTakeQuoted;
            end else begin
              emit_o           = 1'b1;
              res_o.out_char   = char_i;
              res_o.char_valid = 1'b1;
              mode_o           = ModeTakePlain;
            end
          end else if (is_comma) begin
            count_o = count_inc;
            mode_o  = ModeStart;
          end else if (is_quote) begin
            mode_o = ModeSkipQuoted;
          end else begin
            mode_o = ModeSkipPlain;
          end
        end
        ModeSkipPlain: begin
          if (is_nul) begin
            emit_o          = 1'b1;
            res_o.field_end = 1'b1;
            mode_o          = ModeDone;
          end else if (is_comma) begin
            count_o = count_inc;
            mode_o  = ModeStart;
          end
        end
        ModeSkipQuoted: begin
          if (is_nul) begin
            emit_o          = 1'b1;
            res_o.field_end = 1'b1;
            mode_o          = ModeDone;
          end else if (is_quote) begin
            mode_o = ModeSkipQpend;
          end
        end
        ModeSkipQpend: begin
          if (is_nul) begin
            emit_o          = 1'b1;
            res_o.field_end = 1'b1;
            mode_o          = ModeDone;
          end else if (is_quote) begin
            mode_o = ModeSkipQuoted;
          end else begin
            count_o = count_inc;
            mode_o  = ModeStart;
          end
        end
        ModeTakePlain: begin
          emit_o = 1'b1;
          if (is_nul || is_comma) begin
            res_o.field_end = 1'b1;
            mode_o          = ModeDone;
          end else begin
            res_o.out_char   = char_i;
            res_o.char_valid = 1'b1;
          end
        end
        ModeTakeQuoted: begin
          if (is_nul) begin
            emit_o          = 1'b1;
            res_o.field_end = 1'b1;
            mode_o          = ModeDone;
          end else if (is_quote) begin
            mode_o = ModeTakeQpend;
          end else begin
            emit_o           = 1'b1;
            res_o.out_char   = char_i;
            res_o.char_valid = 1'b1;
          end
        end
        ModeTakeQpend: begin
          emit_o = 1'b1;
          if (is_quote) begin
            res_o.out_char   = CharQuote;
            res_o.char_valid = 1'b1;
            mode_o           = ModeTakeQuoted;
          end else begin
            res_o.field_end = 1'b1;
            mode_o          = ModeDone;
          end
        end
        ModeDone: begin
          mode_o = ModeDone;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/csvfe_out_reg.sv @@
module csvfe_out_reg import csvfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  csvfe_res_t res_i,
  output logic       free_o,
  output logic       valid_o,
  input  logic       ready_i,
  output csvfe_res_t res_o
);

  logic       vld_q, vld_d;
  csvfe_res_t res_q;

  // slot can take a word when empty or draining this cycle
  assign free_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

@@ hw/rtl/csv_field_extractor_core.sv @@
// CSV field extractor: takes one character word per cycle on the input channel, with
// end_of_record marking the record terminator, and returns the unescaped characters of
// the field chosen by the field_index register followed by one field_end word per
// record; quoted fields have doubled quotes collapsed and a NUL ends the record early.
// A word is accepted every cycle when the output side keeps up, and its result reaches
// the output through the input register and then the output register: the word sits in
// the input register, and the scan state update loads the output register when it advances. Words
// that give no result (quotes, skipped fields) never wait on the output channel.
// Write field_index only while idle.
module csv_field_extractor_core import csvfe_pkg::*; #(
  parameter int INDEX_BITS = DefIndexBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [FieldIndexW-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CharW-1:0]       in_char_i,
  input  logic                   end_of_record_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CharW-1:0]       out_char_o,
  output logic                   char_valid_o,
  output logic                   field_end_o
);

  logic [FieldIndexW-1:0] field_index_q;
  logic                   in_vld_q, in_vld_d;
  logic [CharW-1:0]       in_char_q;
  logic                   in_eor_q;
  logic [ModeW-1:0]       mode_q, mode_d;
  logic [INDEX_BITS-1:0]  count_q, count_d;
  logic                   emit;
  logic                   slot_free;
  logic                   fire;
  logic                   in_take;
  csvfe_res_t             step_res;
  csvfe_res_t             out_res;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_index_q <= FieldIndexW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      field_index_q <= cfg_data_i;
    end
  end

  // scan logic on the held word
  csvfe_step #(
    .INDEX_BITS(INDEX_BITS)
  ) u_step (
    .mode_i       (mode_q),
    .count_i      (count_q),
    .field_index_i(field_index_q),
    .char_i       (in_char_q),
    .eor_i        (in_eor_q),
    .mode_o       (mode_d),
    .count_o      (count_d),
    .emit_o       (emit),
    .res_o        (step_res)
  );

  // held word advances unless its result has nowhere to go
  assign fire       = in_vld_q && (!emit || slot_free);
  assign in_ready_o = !in_vld_q || fire;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // input word payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= in_char_i;
      in_eor_q  <= end_of_record_i;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeStart;
      count_q <= INDEX_BITS'(1);
    end else if (fire) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  // output register
  csvfe_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && emit),
    .res_i  (step_res),
    .free_o (slot_free),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (out_res)
  );

  assign out_char_o   = out_res.out_char;
  assign char_valid_o = out_res.char_valid;
  assign field_end_o  = out_res.field_end;

  // a result word is either a character or the field end, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_valid_o != field_end_o))
    else $error("result word must carry exactly one of char or field end");

  // an end word carries a zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_end_o |-> (out_char_o == '0))
    else $error("field end word carries a character");

  // once the field is closed only the terminator moves on, and silently
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && (mode_q == ModeDone) |-> !emit)
    else $error("result produced after field end");

  // a terminator always brings the scan back to the start of a record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_eor_q |=> (mode_q == ModeStart) && (count_q == INDEX_BITS'(1)))
    else $error("scan state not reset after end of record");

  // a held word that cannot advance stays in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q && $stable(in_char_q) && $stable(in_eor_q))
    else $error("stalled input word lost");

endmodule
